// ----- rtl/command_packet_parser_core_macros.svh -----
// Assertion macros shared by the command packet parser checker.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef COMMAND_PACKET_PARSER_CORE_MACROS_SVH
`define COMMAND_PACKET_PARSER_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CPP_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("command packet parser assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define CPP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("command packet parser assertion failed");

// Next-cycle implication that is also checked during reset.
`define CPP_ASSERT_NEXT_ALWAYS(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("command packet parser assertion failed");

`endif

// ----- rtl/cpp_pkg.sv -----
// Shared types and constants for the command packet parser.
// Used by the channel interfaces, the result queue and the top level.
`default_nettype none

package cpp_pkg;

  localparam int LENGTH_BITS_DEF = 32;
  localparam int QUEUE_DEPTH_DEF = 4;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 8;

  localparam logic [CFG_INDEX_W-1:0] CFG_PACKET_MAGIC = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_HEADER_LEN   = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_PARAM_MAGIC  = 2'd2;

  localparam logic [1:0] KIND_HEADER = 2'd0;
  localparam logic [1:0] KIND_TYPE   = 2'd1;
  localparam logic [1:0] KIND_DATA   = 2'd2;
  localparam logic [1:0] KIND_STATUS = 2'd3;

  localparam logic [2:0] ST_OK           = 3'd0;
  localparam logic [2:0] ST_PACKET_MAGIC = 3'd1;
  localparam logic [2:0] ST_SIZE         = 3'd2;
  localparam logic [2:0] ST_HEADER_LEN   = 3'd3;
  localparam logic [2:0] ST_PARAM_MAGIC  = 3'd4;
  localparam logic [2:0] ST_TRUNCATED    = 3'd5;
  localparam logic [2:0] ST_BAD_LENGTH   = 3'd6;

  typedef struct packed {
    logic [1:0] result_kind;
    logic [7:0] byte_value;
    logic [6:0] param_number;
    logic       field_end;
    logic [1:0] command_type;
    logic [5:0] command_code;
    logic [6:0] param_total;
    logic [2:0] status_code;
    logic       result_last;
  } result_t;

  typedef struct packed {
    logic push_a;
    logic push_b;
    logic pop;
  } queue_ctrl_t;

endpackage

`default_nettype wire

// ----- rtl/cpp_channels.sv -----
// Valid/ready channel interfaces of the command packet parser.
// Depends on cpp_pkg for the configuration port widths.
`default_nettype none

interface cpp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       buffer_end;

  modport source (output valid, data_byte, buffer_end, input ready);
  modport sink (input valid, data_byte, buffer_end, output ready);
  modport mon (input valid, ready, data_byte, buffer_end);
endinterface

interface cpp_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] result_kind;
  logic [7:0] byte_value;
  logic [6:0] param_number;
  logic       field_end;
  logic [1:0] command_type;
  logic [5:0] command_code;
  logic [6:0] param_total;
  logic [2:0] status_code;
  logic       result_last;

  modport source (output valid, result_kind, byte_value, param_number, field_end,
                  command_type, command_code, param_total, status_code, result_last,
                  input ready);
  modport sink (input valid, result_kind, byte_value, param_number, field_end,
                command_type, command_code, param_total, status_code, result_last,
                output ready);
  modport mon (input valid, ready, result_kind, byte_value, param_number, field_end,
               command_type, command_code, param_total, status_code, result_last);
endinterface

interface cpp_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [cpp_pkg::CFG_INDEX_W-1:0] index;
  logic [cpp_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
  modport mon (input valid, ready, index, data);
endinterface

`default_nettype wire

// ----- rtl/cpp_result_queue.sv -----
// Small result queue that takes up to two items per cycle and gives one.
// Depends on cpp_pkg for the result and control types.
`default_nettype none

module cpp_result_queue #(
  parameter int DEPTH = cpp_pkg::QUEUE_DEPTH_DEF
) (
  input  wire                       clk,
  input  wire                       rst_n,
  input  wire cpp_pkg::queue_ctrl_t ctrl,
  input  wire cpp_pkg::result_t     res_a,
  input  wire cpp_pkg::result_t     res_b,
  output cpp_pkg::result_t          head,
  output logic [$clog2(DEPTH+1)-1:0] count
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  cpp_pkg::result_t slot_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [PW-1:0] wr_ptr_b;

  function automatic logic [PW-1:0] ptr_incr(input logic [PW-1:0] p);
    ptr_incr = (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_comb begin
    wr_ptr_b   = ptr_incr(wr_ptr_r);
    wr_ptr_nxt = wr_ptr_r;
    if (ctrl.push_a && ctrl.push_b) begin
      wr_ptr_nxt = ptr_incr(wr_ptr_b);
    end else if (ctrl.push_a) begin
      wr_ptr_nxt = wr_ptr_b;
    end
    rd_ptr_nxt = ctrl.pop ? ptr_incr(rd_ptr_r) : rd_ptr_r;
    count_nxt  = count_r + CW'(ctrl.push_a) + CW'(ctrl.push_b) - CW'(ctrl.pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.push_a) begin
      slot_r[wr_ptr_r] <= res_a;
    end
    if (ctrl.push_b) begin
      slot_r[wr_ptr_b] <= res_b;
    end
  end

  assign head  = slot_r[rd_ptr_r];
  assign count = count_r;

endmodule

`default_nettype wire

// ----- rtl/command_packet_parser_core.sv -----
// A byte's results are queued as the byte is taken; the output shows the result queue head.
// Throughput: one byte per cycle while the result queue has room for two results; a count, type
// or data byte that also ends the buffer gives two results, which leave one per cycle if ready.
// The queue depth (QUEUE_DEPTH) sets how long input keeps flowing while the output stalls.
// Reset: synchronous, active low; clears parse state, configuration registers and the queue.
// Depends on cpp_pkg, cpp_channels and cpp_result_queue.
`default_nettype none

module command_packet_parser_core #(
  parameter int LENGTH_BITS = cpp_pkg::LENGTH_BITS_DEF,
  parameter int QUEUE_DEPTH = cpp_pkg::QUEUE_DEPTH_DEF
) (
  input  wire       clk,
  input  wire       rst_n,
  cpp_in_if.sink    in_ch,
  cpp_out_if.source out_ch,
  cpp_cfg_if.sink   cfg_ch
);

  localparam int LW = LENGTH_BITS - 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  localparam logic [3:0] PH_PMAGIC = 4'd0;
  localparam logic [3:0] PH_SIZE   = 4'd1;
  localparam logic [3:0] PH_HDR    = 4'd2;
  localparam logic [3:0] PH_CMD    = 4'd3;
  localparam logic [3:0] PH_COUNT  = 4'd4;
  localparam logic [3:0] PH_RMAGIC = 4'd5;
  localparam logic [3:0] PH_TLEN   = 4'd6;
  localparam logic [3:0] PH_DLEN   = 4'd7;
  localparam logic [3:0] PH_TYPE   = 4'd8;
  localparam logic [3:0] PH_DATA   = 4'd9;
  localparam logic [3:0] PH_DONE   = 4'd10;
  localparam logic [3:0] PH_ERR    = 4'd11;

  logic [7:0] pmagic_r, hlen_r, rmagic_r;

  logic [3:0]    phase_r, phase_nxt;
  logic [1:0]    wcnt_r, wcnt_nxt;
  logic [31:0]   word_r, word_nxt;
  logic [31:0]   declared_r, declared_nxt;
  logic [31:0]   rcv_r, rcv_nxt;
  logic [LW-1:0] tleft_r, tleft_nxt;
  logic [LW-1:0] dleft_r, dleft_nxt;
  logic [6:0]    pleft_r, pleft_nxt;
  logic [6:0]    cur_r, cur_nxt;
  logic [2:0]    err_r, err_nxt;
  logic [7:0]    cmd_r, cmd_nxt;
  logic          size_done_r, size_done_nxt;

  logic                 in_acc;
  logic [7:0]           b;
  logic [31:0]          word_full;
  logic                 len_bad;
  logic [6:0]           cnt7;
  logic [3:0]           end_phase;
  logic [2:0]           status;
  cpp_pkg::result_t     res_a, res_b, head;
  cpp_pkg::queue_ctrl_t qctrl;
  logic [CW-1:0]        qcount;

  assign in_ch.ready  = (qcount <= CW'(QUEUE_DEPTH - 2));
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;
  assign b            = in_ch.data_byte;
  assign word_full    = {b, word_r[23:0]};
  assign len_bad      = |word_full[31:LW];
  assign cnt7         = b[7] ? 7'd0 : b[6:0];
  assign end_phase    = (pleft_r == 7'd1) ? PH_DONE : PH_RMAGIC;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pmagic_r <= '0;
      hlen_r   <= '0;
      rmagic_r <= '0;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      case (cfg_ch.index)
        cpp_pkg::CFG_PACKET_MAGIC: pmagic_r <= cfg_ch.data;
        cpp_pkg::CFG_HEADER_LEN:   hlen_r   <= cfg_ch.data;
        cpp_pkg::CFG_PARAM_MAGIC:  rmagic_r <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  always_comb begin
    phase_nxt     = phase_r;
    wcnt_nxt      = wcnt_r;
    word_nxt      = word_r;
    declared_nxt  = declared_r;
    rcv_nxt       = rcv_r;
    tleft_nxt     = tleft_r;
    dleft_nxt     = dleft_r;
    pleft_nxt     = pleft_r;
    cur_nxt       = cur_r;
    err_nxt       = err_r;
    cmd_nxt       = cmd_r;
    size_done_nxt = size_done_r;
    res_a         = '0;
    res_b         = '0;
    qctrl         = '0;
    status        = cpp_pkg::ST_OK;

    if (in_acc) begin
      if (rcv_r != '1) begin
        rcv_nxt = rcv_r + 32'd1;
      end
      if (phase_r == PH_SIZE || phase_r == PH_TLEN || phase_r == PH_DLEN) begin
        word_nxt = word_r | ({24'd0, b} << {wcnt_r, 3'b000});
        wcnt_nxt = wcnt_r + 2'd1;
      end

      case (phase_r)
        PH_PMAGIC: begin
          if (b != pmagic_r) begin
            err_nxt   = cpp_pkg::ST_PACKET_MAGIC;
            phase_nxt = PH_ERR;
          end else begin
            phase_nxt = PH_SIZE;
            wcnt_nxt  = '0;
            word_nxt  = '0;
          end
        end
        PH_SIZE: begin
          if (wcnt_r == 2'd3) begin
            declared_nxt  = word_full;
            size_done_nxt = 1'b1;
            phase_nxt     = PH_HDR;
          end
        end
        PH_HDR: begin
          if (b != hlen_r) begin
            err_nxt   = cpp_pkg::ST_HEADER_LEN;
            phase_nxt = PH_ERR;
          end else begin
            phase_nxt = PH_CMD;
          end
        end
        PH_CMD: begin
          cmd_nxt   = b;
          phase_nxt = PH_COUNT;
        end
        PH_COUNT: begin
          res_a.result_kind  = cpp_pkg::KIND_HEADER;
          res_a.command_type = cmd_r[7:6];
          res_a.command_code = cmd_r[5:0];
          res_a.param_total  = cnt7;
          res_a.result_last  = 1'b1;
          qctrl.push_a       = 1'b1;
          pleft_nxt          = cnt7;
          cur_nxt            = '0;
          phase_nxt          = (cnt7 == 7'd0) ? PH_DONE : PH_RMAGIC;
        end
        PH_RMAGIC: begin
          if (b != rmagic_r) begin
            err_nxt   = cpp_pkg::ST_PARAM_MAGIC;
            phase_nxt = PH_ERR;
          end else begin
            phase_nxt = PH_TLEN;
            wcnt_nxt  = '0;
            word_nxt  = '0;
          end
        end
        PH_TLEN: begin
          if (wcnt_r == 2'd3) begin
            if (len_bad) begin
              err_nxt   = cpp_pkg::ST_BAD_LENGTH;
              phase_nxt = PH_ERR;
            end else begin
              tleft_nxt = word_full[LW-1:0];
              word_nxt  = '0;
              phase_nxt = PH_DLEN;
            end
          end
        end
        PH_DLEN: begin
          if (wcnt_r == 2'd3) begin
            if (len_bad) begin
              err_nxt   = cpp_pkg::ST_BAD_LENGTH;
              phase_nxt = PH_ERR;
            end else begin
              dleft_nxt = word_full[LW-1:0];
              word_nxt  = '0;
              if (tleft_r != '0) begin
                phase_nxt = PH_TYPE;
              end else if (word_full[LW-1:0] != '0) begin
                phase_nxt = PH_DATA;
              end else begin
                cur_nxt   = cur_r + 7'd1;
                pleft_nxt = pleft_r - 7'd1;
                phase_nxt = end_phase;
              end
            end
          end
        end
        PH_TYPE: begin
          tleft_nxt          = tleft_r - 1'b1;
          res_a.result_kind  = cpp_pkg::KIND_TYPE;
          res_a.byte_value   = b;
          res_a.param_number = cur_r;
          res_a.field_end    = (tleft_r == LW'(1));
          res_a.result_last  = 1'b1;
          qctrl.push_a       = 1'b1;
          if (tleft_r == LW'(1)) begin
            if (dleft_r != '0) begin
              phase_nxt = PH_DATA;
            end else begin
              cur_nxt   = cur_r + 7'd1;
              pleft_nxt = pleft_r - 7'd1;
              phase_nxt = end_phase;
            end
          end
        end
        PH_DATA: begin
          dleft_nxt          = dleft_r - 1'b1;
          res_a.result_kind  = cpp_pkg::KIND_DATA;
          res_a.byte_value   = b;
          res_a.param_number = cur_r;
          res_a.field_end    = (dleft_r == LW'(1));
          res_a.result_last  = 1'b1;
          qctrl.push_a       = 1'b1;
          if (dleft_r == LW'(1)) begin
            cur_nxt   = cur_r + 7'd1;
            pleft_nxt = pleft_r - 7'd1;
            phase_nxt = end_phase;
          end
        end
        default: ;
      endcase

      if (in_ch.buffer_end) begin
        if (err_nxt == cpp_pkg::ST_PACKET_MAGIC) begin
          status = cpp_pkg::ST_PACKET_MAGIC;
        end else if (!size_done_nxt) begin
          status = cpp_pkg::ST_TRUNCATED;
        end else if (declared_nxt != rcv_nxt) begin
          status = cpp_pkg::ST_SIZE;
        end else if (err_nxt != cpp_pkg::ST_OK) begin
          status = err_nxt;
        end else if (phase_nxt != PH_DONE) begin
          status = cpp_pkg::ST_TRUNCATED;
        end else begin
          status = cpp_pkg::ST_OK;
        end

        if (qctrl.push_a) begin
          res_a.result_last = 1'b0;
          res_b.result_kind = cpp_pkg::KIND_STATUS;
          res_b.status_code = status;
          res_b.result_last = 1'b1;
          qctrl.push_b      = 1'b1;
        end else begin
          res_a.result_kind = cpp_pkg::KIND_STATUS;
          res_a.status_code = status;
          res_a.result_last = 1'b1;
          qctrl.push_a      = 1'b1;
        end

        phase_nxt     = PH_PMAGIC;
        wcnt_nxt      = '0;
        word_nxt      = '0;
        declared_nxt  = '0;
        rcv_nxt       = '0;
        tleft_nxt     = '0;
        dleft_nxt     = '0;
        pleft_nxt     = '0;
        cur_nxt       = '0;
        err_nxt       = cpp_pkg::ST_OK;
        cmd_nxt       = '0;
        size_done_nxt = 1'b0;
      end
    end

    qctrl.pop = out_ch.valid && out_ch.ready;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_PMAGIC;
      wcnt_r      <= '0;
      word_r      <= '0;
      declared_r  <= '0;
      rcv_r       <= '0;
      tleft_r     <= '0;
      dleft_r     <= '0;
      pleft_r     <= '0;
      cur_r       <= '0;
      err_r       <= cpp_pkg::ST_OK;
      cmd_r       <= '0;
      size_done_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      wcnt_r      <= wcnt_nxt;
      word_r      <= word_nxt;
      declared_r  <= declared_nxt;
      rcv_r       <= rcv_nxt;
      tleft_r     <= tleft_nxt;
      dleft_r     <= dleft_nxt;
      pleft_r     <= pleft_nxt;
      cur_r       <= cur_nxt;
      err_r       <= err_nxt;
      cmd_r       <= cmd_nxt;
      size_done_r <= size_done_nxt;
    end
  end

  cpp_result_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_result_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .ctrl  (qctrl),
    .res_a (res_a),
    .res_b (res_b),
    .head  (head),
    .count (qcount)
  );

  assign out_ch.valid        = (qcount != '0);
  assign out_ch.result_kind  = head.result_kind;
  assign out_ch.byte_value   = head.byte_value;
  assign out_ch.param_number = head.param_number;
  assign out_ch.field_end    = head.field_end;
  assign out_ch.command_type = head.command_type;
  assign out_ch.command_code = head.command_code;
  assign out_ch.param_total  = head.param_total;
  assign out_ch.status_code  = head.status_code;
  assign out_ch.result_last  = head.result_last;

endmodule

`default_nettype wire

// ----- rtl/cpp_checker.sv -----
// Port-level checks for the command packet parser, bound to the top level.
// Depends on cpp_channels and command_packet_parser_core_macros.svh.
`default_nettype none

`include "command_packet_parser_core_macros.svh"

module cpp_checker (
  input wire        clk,
  input wire        rst_n,
  cpp_in_if.sink    in_ch,
  cpp_out_if.source out_ch
);

  `CPP_ASSERT_NEXT_ALWAYS(a_reset_empties, !rst_n, !out_ch.valid)

  `CPP_ASSERT_SAME(a_stall_means_pending, !in_ch.ready, out_ch.valid)

  `CPP_ASSERT_SAME(a_result_needs_input, $rose(out_ch.valid), $past(in_ch.valid && in_ch.ready))

  `CPP_ASSERT_NEXT(a_out_hold, out_ch.valid && !out_ch.ready, out_ch.valid && $stable(out_ch.byte_value))

endmodule

bind command_packet_parser_core cpp_checker u_cpp_checker (
  .clk    (clk),
  .rst_n  (rst_n),
  .in_ch  (in_ch),
  .out_ch (out_ch)
);

`default_nettype wire

// ----- tb/sv/tb_command_packet_parser_core.sv -----
// Self-checking testbench for command_packet_parser_core: it sends byte buffers with
// random gaps and output stalls and checks every result against a parser model kept here.
// Depends on cpp_pkg, the channel interfaces in cpp_channels and the RTL top level.
`default_nettype none

module tb_command_packet_parser_core;

  localparam logic [cpp_pkg::CFG_INDEX_W-1:0] CFG_UNUSED_INDEX = 2'd3;
  localparam int RANDOM_PHASE_ITEMS = 270;
  localparam int IDLE_PAUSE = 8;

  typedef enum logic [3:0] {
    P_PKT_MAGIC, P_SIZE, P_HDR_LEN, P_COMMAND, P_COUNT, P_PAR_MAGIC,
    P_TYPE_LEN, P_DATA_LEN, P_TYPE_BYTES, P_DATA_BYTES, P_DONE, P_HALTED
  } parse_phase_t;

  typedef enum int {
    F_NONE, F_PKT_MAGIC, F_SIZE, F_HDR, F_PAR_MAGIC, F_TRUNC, F_BAD_LEN,
    F_BIG_COUNT, F_HUGE_LEN
  } packet_fault_t;

  logic clk = 1'b0;
  logic rst_n;

  cpp_in_if  in_ch();
  cpp_out_if out_ch();
  cpp_cfg_if cfg_ch();

  command_packet_parser_core DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always #10 clk = ~clk;

  // Parser model state and its copy of the registers.
  parse_phase_t m_phase;
  logic [1:0]   m_word_idx;
  logic [31:0]  m_word;
  logic [31:0]  m_decl_size;
  logic [31:0]  m_rx_count;
  logic [31:0]  m_type_left;
  logic [31:0]  m_data_left;
  logic [6:0]   m_params_left;
  logic [6:0]   m_param_idx;
  logic [2:0]   m_err;
  logic [7:0]   m_cmd;
  logic         m_size_seen;
  logic [7:0]   m_pkt_magic = 8'h00;
  logic [7:0]   m_hdr_len = 8'h00;
  logic [7:0]   m_par_magic = 8'h00;

  // Register values the stimulus builds packets for.
  logic [7:0] want_pkt_magic = 8'h00;
  logic [7:0] want_hdr_len = 8'h00;
  logic [7:0] want_par_magic = 8'h00;

  cpp_pkg::result_t results_due[$];
  cpp_pkg::result_t got_result;
  cpp_pkg::result_t due_result;
  logic [7:0]       pkt_q[$];
  int               fail_count = 0;
  int               results_seen = 0;
  int               items_sent = 0;
  int               burst_left = 0;
  int unsigned      ready_hold = 0;
  int unsigned      ready_pick;

  task automatic log_mismatch(input string msg);
    fail_count++;
    if (fail_count <= 80) $display("MISMATCH result %0d: %s", results_seen, msg);
  endtask

  task automatic compare_field(input string name, input logic [7:0] got, input logic [7:0] want);
    if (got !== want) log_mismatch($sformatf("%s got %0h want %0h", name, got, want));
  endtask

  function automatic void clear_parser_model();
    m_phase = P_PKT_MAGIC;
    m_word_idx = '0;
    m_word = '0;
    m_decl_size = '0;
    m_rx_count = '0;
    m_type_left = '0;
    m_data_left = '0;
    m_params_left = '0;
    m_param_idx = '0;
    m_err = cpp_pkg::ST_OK;
    m_cmd = '0;
    m_size_seen = 1'b0;
  endfunction

  function automatic void note_error(input logic [2:0] code);
    if (m_err == cpp_pkg::ST_OK) m_err = code;
    m_phase = P_HALTED;
  endfunction

  function automatic logic take_word(input logic [7:0] b);
    m_word = m_word | (32'(b) << (8 * m_word_idx));
    if (m_word_idx == 2'd3) begin
      m_word_idx = '0;
      return 1'b1;
    end
    m_word_idx = m_word_idx + 2'd1;
    return 1'b0;
  endfunction

  function automatic void close_param();
    m_param_idx = m_param_idx + 7'd1;
    m_params_left = m_params_left - 7'd1;
    m_phase = (m_params_left == 7'd0) ? P_DONE : P_PAR_MAGIC;
  endfunction

  function automatic void after_length_words();
    if (m_type_left != 0) m_phase = P_TYPE_BYTES;
    else if (m_data_left != 0) m_phase = P_DATA_BYTES;
    else close_param();
  endfunction

  function automatic logic length_too_big(input logic [31:0] v);
    return (v >> (cpp_pkg::LENGTH_BITS_DEF - 1)) != 0;
  endfunction

  function automatic void advance_parser_model(input logic [7:0] b, input logic buf_end);
    cpp_pkg::result_t r[2];
    int               n;
    logic [6:0]       cnt;
    logic [2:0]       st;
    n = 0;
    r[0] = '0;
    r[1] = '0;
    if (m_rx_count != 32'hFFFF_FFFF) m_rx_count = m_rx_count + 32'd1;
    case (m_phase)
      P_PKT_MAGIC: begin
        if (b != m_pkt_magic) note_error(cpp_pkg::ST_PACKET_MAGIC);
        else begin
          m_phase = P_SIZE;
          m_word_idx = '0;
          m_word = '0;
        end
      end
      P_SIZE: begin
        if (take_word(b)) begin
          m_decl_size = m_word;
          m_size_seen = 1'b1;
          m_phase = P_HDR_LEN;
        end
      end
      P_HDR_LEN: begin
        if (b != m_hdr_len) note_error(cpp_pkg::ST_HEADER_LEN);
        else m_phase = P_COMMAND;
      end
      P_COMMAND: begin
        m_cmd = b;
        m_phase = P_COUNT;
      end
      P_COUNT: begin
        cnt = b[7] ? 7'd0 : b[6:0];
        r[n].result_kind = cpp_pkg::KIND_HEADER;
        r[n].command_type = m_cmd[7:6];
        r[n].command_code = m_cmd[5:0];
        r[n].param_total = cnt;
        n++;
        m_params_left = cnt;
        m_param_idx = '0;
        m_phase = (cnt == 7'd0) ? P_DONE : P_PAR_MAGIC;
      end
      P_PAR_MAGIC: begin
        if (b != m_par_magic) note_error(cpp_pkg::ST_PARAM_MAGIC);
        else begin
          m_phase = P_TYPE_LEN;
          m_word_idx = '0;
          m_word = '0;
        end
      end
      P_TYPE_LEN: begin
        if (take_word(b)) begin
          if (length_too_big(m_word)) note_error(cpp_pkg::ST_BAD_LENGTH);
          else begin
            m_type_left = m_word;
            m_word = '0;
            m_phase = P_DATA_LEN;
          end
        end
      end
      P_DATA_LEN: begin
        if (take_word(b)) begin
          if (length_too_big(m_word)) note_error(cpp_pkg::ST_BAD_LENGTH);
          else begin
            m_data_left = m_word;
            m_word = '0;
            after_length_words();
          end
        end
      end
      P_TYPE_BYTES: begin
        m_type_left = m_type_left - 32'd1;
        r[n].result_kind = cpp_pkg::KIND_TYPE;
        r[n].byte_value = b;
        r[n].param_number = m_param_idx;
        r[n].field_end = (m_type_left == 0);
        n++;
        if (m_type_left == 0) after_length_words();
      end
      P_DATA_BYTES: begin
        m_data_left = m_data_left - 32'd1;
        r[n].result_kind = cpp_pkg::KIND_DATA;
        r[n].byte_value = b;
        r[n].param_number = m_param_idx;
        r[n].field_end = (m_data_left == 0);
        n++;
        if (m_data_left == 0) close_param();
      end
      default: ;
    endcase
    if (buf_end) begin
      if (m_err == cpp_pkg::ST_PACKET_MAGIC) st = cpp_pkg::ST_PACKET_MAGIC;
      else if (!m_size_seen) st = cpp_pkg::ST_TRUNCATED;
      else if (m_decl_size != m_rx_count) st = cpp_pkg::ST_SIZE;
      else if (m_err != cpp_pkg::ST_OK) st = m_err;
      else if (m_phase != P_DONE) st = cpp_pkg::ST_TRUNCATED;
      else st = cpp_pkg::ST_OK;
      r[n].result_kind = cpp_pkg::KIND_STATUS;
      r[n].status_code = st;
      n++;
      clear_parser_model();
    end
    if (n > 0) r[n-1].result_last = 1'b1;
    for (int i = 0; i < n; i++) results_due.push_back(r[i]);
  endfunction

  // Results, register writes and accepted bytes are all taken from the same edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        got_result.result_kind = out_ch.result_kind;
        got_result.byte_value = out_ch.byte_value;
        got_result.param_number = out_ch.param_number;
        got_result.field_end = out_ch.field_end;
        got_result.command_type = out_ch.command_type;
        got_result.command_code = out_ch.command_code;
        got_result.param_total = out_ch.param_total;
        got_result.status_code = out_ch.status_code;
        got_result.result_last = out_ch.result_last;
        if (results_due.size() == 0) begin
          log_mismatch($sformatf("unexpected result %h", got_result));
        end else begin
          due_result = results_due.pop_front();
          compare_field("result_kind", 8'(got_result.result_kind), 8'(due_result.result_kind));
          compare_field("byte_value", got_result.byte_value, due_result.byte_value);
          compare_field("param_number", 8'(got_result.param_number),
                        8'(due_result.param_number));
          compare_field("field_end", 8'(got_result.field_end), 8'(due_result.field_end));
          compare_field("command_type", 8'(got_result.command_type),
                        8'(due_result.command_type));
          compare_field("command_code", 8'(got_result.command_code),
                        8'(due_result.command_code));
          compare_field("param_total", 8'(got_result.param_total),
                        8'(due_result.param_total));
          compare_field("status_code", 8'(got_result.status_code), 8'(due_result.status_code));
          compare_field("result_last", 8'(got_result.result_last), 8'(due_result.result_last));
        end
        results_seen++;
      end
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.index)
          cpp_pkg::CFG_PACKET_MAGIC: m_pkt_magic = cfg_ch.data;
          cpp_pkg::CFG_HEADER_LEN:   m_hdr_len = cfg_ch.data;
          cpp_pkg::CFG_PARAM_MAGIC:  m_par_magic = cfg_ch.data;
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready) advance_parser_model(in_ch.data_byte, in_ch.buffer_end);
    end
  end

  always @(posedge clk) begin
    if (ready_hold != 0) begin
      ready_hold <= ready_hold - 1;
    end else begin
      ready_pick = $urandom_range(99);
      if (ready_pick < 4) begin
        out_ch.ready <= 1'b1;
        ready_hold <= $urandom_range(150, 50);
      end else if (ready_pick < 60) begin
        out_ch.ready <= 1'b1;
        ready_hold <= $urandom_range(6);
      end else if (ready_pick < 88) begin
        out_ch.ready <= 1'b0;
        ready_hold <= $urandom_range(2);
      end else if (ready_pick < 97) begin
        out_ch.ready <= 1'b0;
        ready_hold <= $urandom_range(8, 3);
      end else begin
        out_ch.ready <= 1'b0;
        ready_hold <= $urandom_range(40, 20);
      end
    end
  end

  function automatic int pick_gap();
    int r;
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    r = $urandom_range(99);
    if (r < 5) begin
      burst_left = $urandom_range(80, 30);
      return 0;
    end
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(3, 1);
    if (r < 97) return $urandom_range(10, 4);
    return $urandom_range(40, 15);
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic buf_end);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data_byte <= b;
    in_ch.buffer_end <= buf_end;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic send_packet();
    for (int i = 0; i < pkt_q.size(); i++) send_byte(pkt_q[i], i == pkt_q.size() - 1);
  endtask

  task automatic write_reg(input logic [cpp_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [7:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= value;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
  endtask

  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk);
    repeat (IDLE_PAUSE) @(posedge clk);
  endtask

  task automatic configure(input logic [7:0] pm, input logic [7:0] hl, input logic [7:0] pa);
    wait_idle();
    write_reg(cpp_pkg::CFG_PACKET_MAGIC, pm);
    write_reg(cpp_pkg::CFG_HEADER_LEN, hl);
    write_reg(cpp_pkg::CFG_PARAM_MAGIC, pa);
    cfg_ch.valid <= 1'b0;
    want_pkt_magic = pm;
    want_hdr_len = hl;
    want_par_magic = pa;
  endtask

  function automatic logic [7:0] nonzero_byte();
    return 8'($urandom_range(255, 1));
  endfunction

  function automatic logic [31:0] pick_len(input int max_len);
    if ($urandom_range(3) == 0) return 32'd0;
    return 32'($urandom_range(max_len, 1));
  endfunction

  function automatic void build_packet(input int n_par, input int max_len, input int trail,
                                       input packet_fault_t fault);
    int          bad_at;
    int          cut;
    int          total;
    int          body_t;
    int          body_d;
    logic [31:0] tlw;
    logic [31:0] dlw;
    logic [31:0] size_word;
    pkt_q.delete();
    bad_at = (n_par > 0) ? $urandom_range(n_par - 1) : 0;
    pkt_q.push_back((fault == F_PKT_MAGIC) ? want_pkt_magic ^ nonzero_byte() : want_pkt_magic);
    repeat (4) pkt_q.push_back(8'h00);
    pkt_q.push_back((fault == F_HDR) ? want_hdr_len ^ nonzero_byte() : want_hdr_len);
    pkt_q.push_back(8'($urandom()));
    pkt_q.push_back((fault == F_BIG_COUNT) ? 8'($urandom_range(255, 128)) : 8'(n_par));
    for (int i = 0; i < n_par; i++) begin
      pkt_q.push_back((fault == F_PAR_MAGIC && i == bad_at) ?
                      want_par_magic ^ nonzero_byte() : want_par_magic);
      tlw = pick_len(max_len);
      dlw = pick_len(max_len);
      if (fault == F_BAD_LEN && i == bad_at) begin
        if ($urandom_range(1)) tlw = 32'h8000_0000 | 32'($urandom());
        else dlw = 32'h8000_0000 | 32'($urandom());
      end
      if (fault == F_HUGE_LEN && i == bad_at) tlw = 32'h7FFF_FFFF;
      for (int k = 0; k < 4; k++) pkt_q.push_back(tlw[8*k +: 8]);
      for (int k = 0; k < 4; k++) pkt_q.push_back(dlw[8*k +: 8]);
      body_t = (tlw > 32) ? $urandom_range(3) : int'(tlw);
      body_d = (dlw > 32) ? $urandom_range(3) : int'(dlw);
      repeat (body_t + body_d) pkt_q.push_back(8'($urandom()));
    end
    repeat (trail) pkt_q.push_back(8'($urandom()));
    if (fault == F_TRUNC) begin
      cut = $urandom_range(1) ? $urandom_range(5, 1) : $urandom_range(pkt_q.size() - 1, 1);
      while (pkt_q.size() > cut) void'(pkt_q.pop_back());
    end
    total = pkt_q.size();
    size_word = 32'(total);
    if (fault == F_SIZE) size_word = size_word ^ (32'd1 << $urandom_range(31));
    for (int k = 1; k <= 4 && k < total; k++) pkt_q[k] = size_word[8*(k-1) +: 8];
  endfunction

  task automatic send_noise();
    int n;
    n = $urandom_range(8, 1);
    for (int i = 0; i < n; i++) begin
      if (i == 0 && $urandom_range(1)) send_byte(want_pkt_magic, i == n - 1);
      else send_byte(8'($urandom()), i == n - 1);
    end
  endtask

  task automatic test_reset_defaults();
    build_packet(1, 2, 0, F_NONE);
    send_packet();
  endtask

  task automatic test_directed_cases();
    configure(8'hA5, 8'h08, 8'h5A);
    pkt_q = '{8'hA5, 8'h08, 8'h00, 8'h00, 8'h00, 8'h08, 8'hC0, 8'h80};
    send_packet();
    pkt_q = '{8'h00};
    send_packet();
    pkt_q = '{8'hA5, 8'h03, 8'h00};
    send_packet();
    pkt_q = '{8'hA5, 8'h06, 8'h00, 8'h00, 8'h00, 8'h07};
    send_packet();
    pkt_q = '{8'hA5, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h08, 8'h3F, 8'h00};
    send_packet();
  endtask

  task automatic test_unused_index();
    wait_idle();
    write_reg(CFG_UNUSED_INDEX, 8'($urandom()));
    cfg_ch.valid <= 1'b0;
    build_packet(2, 3, 1, F_NONE);
    send_packet();
  endtask

  task automatic test_random_traffic(input logic [7:0] pm, input logic [7:0] hl,
                                     input logic [7:0] pa, input int quota);
    int            start;
    int            pick;
    int            n_par;
    packet_fault_t fault;
    configure(pm, hl, pa);
    start = items_sent;
    while (items_sent - start < quota) begin
      pick = $urandom_range(99);
      if (pick < 6) begin
        send_noise();
      end else begin
        fault = (pick < 70) ? F_NONE :
                packet_fault_t'($urandom_range(int'(F_HUGE_LEN), int'(F_PKT_MAGIC)));
        n_par = ($urandom_range(9) == 0) ? $urandom_range(12, 4) : $urandom_range(3);
        if (n_par == 0 && (fault == F_PAR_MAGIC || fault == F_BAD_LEN || fault == F_HUGE_LEN))
          n_par = 1;
        build_packet(n_par, ($urandom_range(7) == 0) ? 16 : 4,
                     ($urandom_range(4) == 0) ? $urandom_range(4, 1) : 0, fault);
        send_packet();
      end
    end
  endtask

  task automatic finish_run();
    in_ch.valid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk);
    repeat (IDLE_PAUSE) @(posedge clk);
    if (fail_count == 0) $display("command_packet_parser_core verification clean");
    else $display("command_packet_parser_core verification failed");
    $finish;
  endtask

  initial begin
    clear_parser_model();
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.data_byte = 8'h00;
    in_ch.buffer_end = 1'b0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_defaults();
    test_directed_cases();
    test_unused_index();
    test_random_traffic(8'hFF, 8'hFF, 8'hFF, RANDOM_PHASE_ITEMS);
    test_random_traffic(8'h00, 8'h00, 8'h00, RANDOM_PHASE_ITEMS);
    test_random_traffic(8'($urandom()), 8'($urandom()), 8'($urandom()), RANDOM_PHASE_ITEMS);
    test_random_traffic(8'h00, 8'hFF, 8'h80, RANDOM_PHASE_ITEMS);
    test_random_traffic(8'($urandom()), 8'($urandom()), 8'($urandom()), RANDOM_PHASE_ITEMS);
    finish_run();
  end

  initial begin
    #20_000_000;
    $display("command_packet_parser_core verification failed");
    $finish;
  end

endmodule

`default_nettype wire
